// ===== rtl/core/acmc_pkg.sv =====
// Package for the alarm clock mode controller: mode and event codes,
// state and result structs, wrap limits. No dependencies.
package acmc_pkg;

  typedef enum logic [2:0] {
    MODE_DISPLAY   = 3'd0,
    MODE_SET_TIME  = 3'd1,
    MODE_WATCH     = 3'd2,
    MODE_SET_ALARM = 3'd3,
    MODE_BRIGHT    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    OP_SW1_SHORT   = 3'd0,
    OP_SW1_HELD    = 3'd1,
    OP_UP          = 3'd2,
    OP_DOWN        = 3'd3,
    OP_LIGHT_TICK  = 3'd4,
    OP_WATCH_TICK  = 3'd5,
    OP_ALARM_CHECK = 3'd6
  } op_e;

  localparam logic [1:0] FIELD_NONE    = 2'd0;
  localparam logic [1:0] FIELD_HOURS   = 2'd1;
  localparam logic [1:0] FIELD_MINUTES = 2'd2;
  localparam logic [1:0] FIELD_SECONDS = 2'd3;

  localparam logic [4:0] HOURS_MAX       = 5'd23;
  localparam logic [5:0] MINSEC_MAX      = 6'd59;
  localparam logic [6:0] WATCH_HOURS_MAX = 7'd99;
  localparam logic [7:0] IDLE_MAX        = 8'd255;

  localparam logic [7:0] LIGHT_TIMEOUT_RST = 8'd60;

  localparam logic signed [1:0] BSTEP_NONE = 2'sd0;
  localparam logic signed [1:0] BSTEP_UP   = 2'sd1;
  localparam logic signed [1:0] BSTEP_DOWN = -2'sd1;

  typedef struct packed {
    mode_e      mode;
    logic [1:0] field;
    logic [4:0] set_hours;
    logic [5:0] set_minutes;
    logic [5:0] set_seconds;
    logic [6:0] watch_hours;
    logic [5:0] watch_minutes;
    logic [5:0] watch_seconds;
    logic       watch_running;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic [5:0] alarm_seconds;
    logic       alarm_armed;
    logic [7:0] idle_seconds;
    logic       light_on;
  } state_t;

  typedef struct packed {
    mode_e             mode;
    logic [1:0]        field_select;
    logic [6:0]        shown_hours;
    logic [5:0]        shown_minutes;
    logic [5:0]        shown_seconds;
    logic              alarm_enabled;
    logic              backlight_on;
    logic              alarm_fire;
    logic              load_clock;
    logic signed [1:0] brightness_step;
  } result_t;

endpackage

// ===== rtl/core/alarm_clock_mode_controller.sv =====
// Top level of the alarm clock mode controller: stream ports, input and
// result registers, controller state. Depends on acmc_pkg, acmc_event_logic.
// Usage:
//   Events enter on the slave stream: s_axis_tuser carries the event code
//   (button 1 short/held, up, down, backlight tick, stopwatch tick, alarm
//   check), s_axis_tdata the clock hour and minute used by the alarm check.
//   Every event yields exactly one status word on the master stream: mode,
//   edited field, the shown hour/minute/second triple, alarm and backlight
//   flags and the alarm, clock-load and brightness strobes.
//   The backlight timeout is written through cfg_we_i/cfg_wdata_i, by the user only
//   while the block is idle (not enforced by the block); it resets to 60 seconds.
// Timing:
//   Input register, combinational event logic, result register: an event is captured
//   in the input register, then its status word in the result register, which raises
//   tvalid. Throughput is one event per cycle while the receiver does not stall.
// Reset and stalls:
//   Reset puts the controller in display mode with all times cleared,
//   alarm disarmed and backlight off, and empties both stages.
//   If the receiver stalls, the result holds and the input register still
//   takes one more event; after that s_axis_tready drops until it drains.
module alarm_clock_mode_controller import acmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
  input  logic [15:0] s_axis_tdata,   // [4:0] clock_hours, [10:5] clock_minutes, rest 0
  // status stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] mode, [4:3] field_select, [11:5] shown_hours,
                                      // [17:12] shown_minutes, [23:18] shown_seconds,
                                      // [24] alarm_enabled, [25] backlight_on,
                                      // [26] alarm_fire, [27] load_clock,
                                      // [29:28] brightness_step, rest 0
  // backlight timeout register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic       in_valid_q;
  logic [2:0] in_op_q;
  logic [4:0] in_hours_q;
  logic [5:0] in_minutes_q;

  logic       out_valid_q;
  result_t    out_res_q;

  logic [7:0] light_timeout_q;
  state_t     state_q, state_d;
  result_t    result_d;

  logic       advance;

  // stage 2 takes the captured event when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_timeout_q <= LIGHT_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      light_timeout_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q      <= s_axis_tuser;
      in_hours_q   <= s_axis_tdata[4:0];
      in_minutes_q <= s_axis_tdata[10:5];
    end
  end

  acmc_event_logic u_event_logic (
    .state_i         (state_q),
    .opcode_i        (in_op_q),
    .clock_hours_i   (in_hours_q),
    .clock_minutes_i (in_minutes_q),
    .light_timeout_i (light_timeout_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  // controller state commits once per event, in order; all-zero is display mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.brightness_step,
                          out_res_q.load_clock,
                          out_res_q.alarm_fire,
                          out_res_q.backlight_on,
                          out_res_q.alarm_enabled,
                          out_res_q.shown_seconds,
                          out_res_q.shown_minutes,
                          out_res_q.shown_hours,
                          out_res_q.field_select,
                          out_res_q.mode};

endmodule

// ===== rtl/core/acmc_event_logic.sv =====
// Per-event next-state and result logic of the alarm clock mode controller.
// Purely combinational; depends on acmc_pkg.
module acmc_event_logic import acmc_pkg::*; (
  input  state_t     state_i,
  input  logic [2:0] opcode_i,
  input  logic [4:0] clock_hours_i,
  input  logic [5:0] clock_minutes_i,
  input  logic [7:0] light_timeout_i,
  output state_t     state_o,
  output result_t    result_o
);

  function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic [5:0] max,
                                           input logic up);
    logic [5:0] r;
    if (up) begin
      r = (v >= max) ? 6'd0 : v + 6'd1;
    end else begin
      r = (v == 6'd0 || v > max) ? max : v - 6'd1;
    end
    return r;
  endfunction

  state_t     st;
  logic       fire, load;
  logic [1:0] bstep;
  logic       up;
  logic [7:0] idle_inc;
  logic [6:0] sec_inc, min_inc;
  logic [7:0] hr_inc;

  assign up = (op_e'(opcode_i) == OP_UP);

  always_comb begin
    st       = state_i;
    fire     = 1'b0;
    load     = 1'b0;
    bstep    = BSTEP_NONE;
    idle_inc = 8'd0;
    sec_inc  = 7'd0;
    min_inc  = 7'd0;
    hr_inc   = 8'd0;

    // any button wakes the backlight
    if (opcode_i <= OP_DOWN) begin
      st.light_on     = 1'b1;
      st.idle_seconds = 8'd0;
    end

    unique case (op_e'(opcode_i))
      OP_SW1_SHORT, OP_SW1_HELD: begin
        unique case (state_i.mode)
          MODE_DISPLAY: begin
            if (op_e'(opcode_i) == OP_SW1_HELD) begin
              st.mode  = MODE_SET_TIME;
              st.field = FIELD_HOURS;
            end else begin
              st.mode  = MODE_WATCH;
              st.field = FIELD_NONE;
            end
          end
          MODE_WATCH: begin
            st.mode  = MODE_SET_ALARM;
            st.field = FIELD_HOURS;
          end
          MODE_SET_TIME: begin
            if (state_i.field == FIELD_HOURS || state_i.field == FIELD_MINUTES) begin
              st.field = state_i.field + 2'd1;
            end else if (state_i.field == FIELD_SECONDS) begin
              st.field = FIELD_NONE;
              st.mode  = MODE_DISPLAY;
              load     = 1'b1;
            end
          end
          MODE_SET_ALARM: begin
            if (state_i.field == FIELD_HOURS || state_i.field == FIELD_MINUTES) begin
              st.field = state_i.field + 2'd1;
            end else if (state_i.field == FIELD_SECONDS) begin
              st.field       = FIELD_NONE;
              st.mode        = MODE_BRIGHT;
              st.alarm_armed = 1'b1;
            end
          end
          default: begin
            st.mode  = MODE_DISPLAY;
            st.field = FIELD_NONE;
          end
        endcase
      end
      OP_UP, OP_DOWN: begin
        unique case (state_i.mode)
          MODE_SET_TIME: begin
            unique case (state_i.field)
              FIELD_HOURS:
                st.set_hours = 5'(wrap_step({1'b0, state_i.set_hours},
                                            {1'b0, HOURS_MAX}, up));
              FIELD_MINUTES: st.set_minutes = wrap_step(state_i.set_minutes, MINSEC_MAX, up);
              FIELD_SECONDS: st.set_seconds = wrap_step(state_i.set_seconds, MINSEC_MAX, up);
              default: ;
            endcase
          end
          MODE_SET_ALARM: begin
            unique case (state_i.field)
              FIELD_HOURS:
                st.alarm_hours = 5'(wrap_step({1'b0, state_i.alarm_hours},
                                              {1'b0, HOURS_MAX}, up));
              FIELD_MINUTES:
                st.alarm_minutes = wrap_step(state_i.alarm_minutes, MINSEC_MAX, up);
              FIELD_SECONDS:
                st.alarm_seconds = wrap_step(state_i.alarm_seconds, MINSEC_MAX, up);
              default: ;
            endcase
          end
          MODE_WATCH: begin
            if (up) begin
              st.watch_running = ~state_i.watch_running;
            end else begin
              st.watch_hours   = 7'd0;
              st.watch_minutes = 6'd0;
              st.watch_seconds = 6'd0;
              st.watch_running = 1'b0;
            end
          end
          MODE_DISPLAY: begin
            if (up) st.alarm_armed = ~state_i.alarm_armed;
          end
          MODE_BRIGHT: bstep = up ? BSTEP_UP : BSTEP_DOWN;
          default: ;
        endcase
      end
      OP_LIGHT_TICK: begin
        idle_inc = (state_i.idle_seconds < IDLE_MAX) ? state_i.idle_seconds + 8'd1
                                                     : state_i.idle_seconds;
        st.idle_seconds = idle_inc;
        if (idle_inc > light_timeout_i) st.light_on = 1'b0;
      end
      OP_WATCH_TICK: begin
        if (state_i.watch_running) begin
          // seconds and minutes carry past 59, hours wrap past 99
          sec_inc = {1'b0, state_i.watch_seconds} + 7'd1;
          min_inc = {1'b0, state_i.watch_minutes};
          hr_inc  = {1'b0, state_i.watch_hours};
          if (sec_inc > {1'b0, MINSEC_MAX}) begin
            sec_inc = 7'd0;
            min_inc = min_inc + 7'd1;
          end
          if (min_inc > {1'b0, MINSEC_MAX}) begin
            min_inc = 7'd0;
            hr_inc  = hr_inc + 8'd1;
          end
          if (hr_inc > {1'b0, WATCH_HOURS_MAX}) hr_inc = 8'd0;
          st.watch_seconds = sec_inc[5:0];
          st.watch_minutes = min_inc[5:0];
          st.watch_hours   = hr_inc[6:0];
        end
      end
      OP_ALARM_CHECK: begin
        fire = state_i.alarm_armed && (clock_hours_i == state_i.alarm_hours)
               && (clock_minutes_i == state_i.alarm_minutes);
      end
      default: ;
    endcase
  end

  assign state_o = st;

  always_comb begin
    result_o                 = '0;
    result_o.mode            = st.mode;
    result_o.field_select    = st.field;
    result_o.alarm_enabled   = st.alarm_armed;
    result_o.backlight_on    = st.light_on;
    result_o.alarm_fire      = fire;
    result_o.load_clock      = load;
    result_o.brightness_step = bstep;
    unique case (st.mode)
      MODE_DISPLAY, MODE_SET_TIME: begin
        result_o.shown_hours   = {2'b00, st.set_hours};
        result_o.shown_minutes = st.set_minutes;
        result_o.shown_seconds = st.set_seconds;
      end
      MODE_WATCH: begin
        result_o.shown_hours   = st.watch_hours;
        result_o.shown_minutes = st.watch_minutes;
        result_o.shown_seconds = st.watch_seconds;
      end
      MODE_SET_ALARM: begin
        result_o.shown_hours   = {2'b00, st.alarm_hours};
        result_o.shown_minutes = st.alarm_minutes;
        result_o.shown_seconds = st.alarm_seconds;
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/alarm_clock_mode_controller_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for alarm_clock_mode_controller. It predicts every status word
// with its own model of the controller and compares the words field by field.
// Depends on acmc_pkg and the controller RTL.
module alarm_clock_mode_controller_test;
  import acmc_pkg::*;

  localparam logic [2:0]  OP_UNUSED     = 3'd7;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned CHUNK_EVENTS  = 170;
  localparam int unsigned RANDOM_CHUNKS = 7;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser  = '0;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;

  alarm_clock_mode_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Controller model state, advanced once per accepted event.
  mode_e      pm_mode;
  logic [1:0] pm_field;
  logic [4:0] tm_h;
  logic [5:0] tm_m, tm_s;
  logic [6:0] sw_h;
  logic [5:0] sw_m, sw_s;
  logic       sw_run;
  logic [4:0] al_h;
  logic [5:0] al_m, al_s;
  logic       al_armed;
  logic [7:0] idle_cnt;
  logic       light;
  logic [7:0] light_timeout;

  result_t     pending_status[$];
  int unsigned mismatch_count = 0;
  int unsigned events_sent    = 0;
  int unsigned status_checked = 0;
  int unsigned timeout_writes = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_request  = 0;
  bit          steady_tx      = 1'b0;
  bit          steady_rx      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Up wraps past max to zero, down wraps below zero (or out of range) to max.
  function automatic logic [6:0] nudge(input logic [6:0] v, input logic [6:0] max,
                                       input bit up);
    if (up) return (v >= max) ? 7'd0 : v + 7'd1;
    return (v == 7'd0 || v > max) ? max : v - 7'd1;
  endfunction

  function automatic result_t next_status(input logic [2:0] op, input logic [4:0] ch,
                                          input logic [5:0] cm);
    result_t r;
    bit      up;
    r  = '0;
    up = (op == OP_UP);
    // any button wakes the backlight
    if (op <= OP_DOWN) begin
      light    = 1'b1;
      idle_cnt = '0;
    end
    case (op)
      OP_SW1_SHORT, OP_SW1_HELD: begin
        case (pm_mode)
          MODE_DISPLAY: begin
            if (op == OP_SW1_HELD) begin
              pm_mode  = MODE_SET_TIME;
              pm_field = FIELD_HOURS;
            end else begin
              pm_mode  = MODE_WATCH;
              pm_field = FIELD_NONE;
            end
          end
          MODE_WATCH: begin
            pm_mode  = MODE_SET_ALARM;
            pm_field = FIELD_HOURS;
          end
          MODE_SET_TIME, MODE_SET_ALARM: begin
            if (pm_field == FIELD_HOURS || pm_field == FIELD_MINUTES) begin
              pm_field = pm_field + 2'd1;
            end else if (pm_field == FIELD_SECONDS) begin
              pm_field = FIELD_NONE;
              if (pm_mode == MODE_SET_TIME) begin
                pm_mode      = MODE_DISPLAY;
                r.load_clock = 1'b1;
              end else begin
                pm_mode  = MODE_BRIGHT;
                al_armed = 1'b1;
              end
            end
          end
          default: begin
            pm_mode  = MODE_DISPLAY;
            pm_field = FIELD_NONE;
          end
        endcase
      end
      OP_UP, OP_DOWN: begin
        case (pm_mode)
          MODE_SET_TIME: begin
            case (pm_field)
              FIELD_HOURS:   tm_h = 5'(nudge(7'(tm_h), 7'(HOURS_MAX), up));
              FIELD_MINUTES: tm_m = 6'(nudge(7'(tm_m), 7'(MINSEC_MAX), up));
              FIELD_SECONDS: tm_s = 6'(nudge(7'(tm_s), 7'(MINSEC_MAX), up));
              default: ;
            endcase
          end
          MODE_SET_ALARM: begin
            case (pm_field)
              FIELD_HOURS:   al_h = 5'(nudge(7'(al_h), 7'(HOURS_MAX), up));
              FIELD_MINUTES: al_m = 6'(nudge(7'(al_m), 7'(MINSEC_MAX), up));
              FIELD_SECONDS: al_s = 6'(nudge(7'(al_s), 7'(MINSEC_MAX), up));
              default: ;
            endcase
          end
          MODE_WATCH: begin
            if (up) begin
              sw_run = ~sw_run;
            end else begin
              sw_h   = '0;
              sw_m   = '0;
              sw_s   = '0;
              sw_run = 1'b0;
            end
          end
          MODE_DISPLAY: begin
            if (up) al_armed = ~al_armed;
          end
          default: r.brightness_step = up ? BSTEP_UP : BSTEP_DOWN;
        endcase
      end
      OP_LIGHT_TICK: begin
        if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 8'd1;
        if (idle_cnt > light_timeout) light = 1'b0;
      end
      OP_WATCH_TICK: begin
        if (sw_run) begin
          if (sw_s == MINSEC_MAX) begin
            sw_s = '0;
            if (sw_m == MINSEC_MAX) begin
              sw_m = '0;
              sw_h = (sw_h == WATCH_HOURS_MAX) ? 7'd0 : sw_h + 7'd1;
            end else begin
              sw_m = sw_m + 6'd1;
            end
          end else begin
            sw_s = sw_s + 6'd1;
          end
        end
      end
      OP_ALARM_CHECK: r.alarm_fire = al_armed && (ch == al_h) && (cm == al_m);
      default: ;
    endcase

    r.mode         = pm_mode;
    r.field_select = pm_field;
    case (pm_mode)
      MODE_DISPLAY, MODE_SET_TIME: begin
        r.shown_hours   = 7'(tm_h);
        r.shown_minutes = tm_m;
        r.shown_seconds = tm_s;
      end
      MODE_WATCH: begin
        r.shown_hours   = sw_h;
        r.shown_minutes = sw_m;
        r.shown_seconds = sw_s;
      end
      MODE_SET_ALARM: begin
        r.shown_hours   = 7'(al_h);
        r.shown_minutes = al_m;
        r.shown_seconds = al_s;
      end
      default: ;
    endcase
    r.alarm_enabled = al_armed;
    r.backlight_on  = light;
    return r;
  endfunction

  // One event transfer; random gaps before it unless the sender runs steady.
  task automatic send_event(input logic [2:0] op, input logic [4:0] ch,
                            input logic [5:0] cm);
    while (!steady_tx && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, cm, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_status.push_back(next_status(op, ch, cm));
    events_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    send_event(op, 5'd0, 6'd0);
  endtask

  task automatic send_random_event();
    int unsigned pick;
    logic [2:0]  op;
    logic [4:0]  ch;
    logic [5:0]  cm;
    pick = $urandom_range(99);
    if (pick < 15)      op = OP_SW1_SHORT;
    else if (pick < 23) op = OP_SW1_HELD;
    else if (pick < 43) op = OP_UP;
    else if (pick < 58) op = OP_DOWN;
    else if (pick < 72) op = OP_LIGHT_TICK;
    else if (pick < 87) op = OP_WATCH_TICK;
    else if (pick < 98) op = OP_ALARM_CHECK;
    else                op = OP_UNUSED;
    ch = 5'($urandom_range(31));
    cm = 6'($urandom_range(63));
    // half of the alarm checks hit the programmed alarm time
    if (op == OP_ALARM_CHECK && $urandom_range(1) == 1) begin
      ch = al_h;
      cm = al_m;
    end else if ($urandom_range(3) != 0) begin
      ch = 5'($urandom_range(23));
      cm = 6'($urandom_range(59));
    end
    send_event(op, ch, cm);
  endtask

  // Stop offering and wait until every status word is back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_light_timeout(input logic [7:0] seconds);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seconds;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    light_timeout = seconds;
    timeout_writes++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: status word %0d, %s expected 0x%0h got 0x%0h",
                 $realtime, status_checked, name, want, got);
    end
  endtask

  // Status side: compare each accepted word with the oldest prediction.
  always @(posedge clk_i) begin : status_check
    result_t     want;
    logic [31:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: status word 0x%08h with no event waiting", $realtime, got);
      end else begin
        want = pending_status.pop_front();
        check_field("mode", 32'(want.mode), 32'(got[2:0]));
        check_field("field_select", 32'(want.field_select), 32'(got[4:3]));
        check_field("shown_hours", 32'(want.shown_hours), 32'(got[11:5]));
        check_field("shown_minutes", 32'(want.shown_minutes), 32'(got[17:12]));
        check_field("shown_seconds", 32'(want.shown_seconds), 32'(got[23:18]));
        check_field("alarm_enabled", 32'(want.alarm_enabled), 32'(got[24]));
        check_field("backlight_on", 32'(want.backlight_on), 32'(got[25]));
        check_field("alarm_fire", 32'(want.alarm_fire), 32'(got[26]));
        check_field("load_clock", 32'(want.load_clock), 32'(got[27]));
        check_field("brightness_step", {30'd0, want.brightness_step}, 32'(got[29:28]));
        check_field("padding", 32'd0, 32'(got[31:30]));
        status_checked++;
      end
    end
  end

  // Status ready: random stalls, steady stretches, and long hold-offs on request.
  initial begin : status_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (stall_request != 0) begin
        hold          = stall_request;
        stall_request = 0;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (steady_rx) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 34);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d status words outstanding",
             cycle_count, pending_status.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Walk every mode, every button and the named corner cases once.
  task automatic test_directed_walk();
    send_op(OP_DOWN);                          // display: nothing to do
    send_op(OP_UP);                            // arm
    send_op(OP_UP);                            // disarm
    send_op(OP_SW1_SHORT);                     // stopwatch
    send_op(OP_UP);                            // start
    send_op(OP_WATCH_TICK);
    send_op(OP_DOWN);                          // clear, stops too
    send_op(OP_WATCH_TICK);                    // stopped: ignored
    send_op(OP_SW1_HELD);                      // held acts as short here: set alarm
    send_op(OP_DOWN);                          // hours 0 -> 23
    send_op(OP_SW1_SHORT);
    send_op(OP_DOWN);                          // minutes 0 -> 59
    send_op(OP_SW1_SHORT);
    send_op(OP_UP);
    send_op(OP_SW1_SHORT);                     // brightness, alarm armed
    send_op(OP_UP);
    send_op(OP_DOWN);
    send_op(OP_SW1_SHORT);                     // display
    send_event(OP_ALARM_CHECK, 5'd23, 6'd59);  // fires
    send_event(OP_ALARM_CHECK, 5'd31, 6'd63);
    send_op(OP_SW1_HELD);                      // display held: set time, hours
    send_op(OP_DOWN);
    send_op(OP_SW1_SHORT);
    send_op(OP_UP);
    send_op(OP_SW1_SHORT);
    send_op(OP_DOWN);
    send_op(OP_SW1_SHORT);                     // load strobe
    send_op(OP_UNUSED);
    send_op(OP_LIGHT_TICK);
  endtask

  // Reset timeout first, then the extremes and one middle value.
  task automatic test_backlight_timeout();
    logic [7:0] timeouts [4] = '{8'd0, 8'd1, 8'd255, 8'd37};
    send_op(OP_DOWN);
    repeat (62) send_op(OP_LIGHT_TICK);
    foreach (timeouts[i]) begin
      set_light_timeout(timeouts[i]);
      send_op(OP_DOWN);
      // 255 never expires; run past the idle counter saturation
      repeat ((timeouts[i] == IDLE_MAX) ? 260 : int'(timeouts[i]) + 3)
        send_op(OP_LIGHT_TICK);
    end
  endtask

  // Receiver holds off while events keep coming, so the input side stalls.
  task automatic test_stall_and_refill();
    steady_tx     = 1'b1;
    stall_request = 80;
    repeat (30) send_random_event();
    steady_tx     = 1'b0;
    settle();
  endtask

  // Stopwatch through several second carries and two minute carries, no idling.
  task automatic test_watch_rollover();
    while (pm_mode != MODE_DISPLAY) send_op(OP_SW1_SHORT);
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    send_op(OP_SW1_SHORT);
    send_op(OP_DOWN);
    send_op(OP_UP);
    repeat (2 * 60 + 10) send_op(OP_WATCH_TICK);
    send_op(OP_UP);
    steady_tx = 1'b0;
    steady_rx = 1'b0;
    settle();
  endtask

  task automatic test_random_events();
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case (chunk)
        0:       set_light_timeout(IDLE_MAX);
        1:       set_light_timeout(8'd0);
        default: set_light_timeout(8'($urandom_range(255)));
      endcase
      steady_tx = (chunk == 3);
      steady_rx = (chunk == 3);
      if (chunk == 5) stall_request = 120;
      repeat (CHUNK_EVENTS) send_random_event();
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  initial begin : main
    pm_mode       = MODE_DISPLAY;
    pm_field      = FIELD_NONE;
    {tm_h, tm_m, tm_s} = '0;
    {sw_h, sw_m, sw_s, sw_run} = '0;
    {al_h, al_m, al_s, al_armed} = '0;
    idle_cnt      = '0;
    light         = 1'b0;
    light_timeout = LIGHT_TIMEOUT_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_walk();
    test_backlight_timeout();
    test_stall_and_refill();
    test_watch_rollover();
    test_random_events();
    settle();

    $display("Ran %0d events through all five modes, %0d status words compared,",
             events_sent, status_checked);
    $display("%0d backlight timeout writes, two receiver hold-offs, stopwatch minute carries.",
             timeout_writes);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d status words missing", mismatch_count,
               pending_status.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
